/* rtl/ccp_pkg.sv */
`timescale 1ns / 1ps

package ccp_pkg;

  // Field widths and fixed-point format.
  localparam int FRAC_BITS  = 9;
  localparam int COORD_BITS = 12;
  localparam int MAX_POINTS = 16;
  localparam int LEVEL_W    = 13;
  // Integer part of a level; the band index field carries exactly these bits.
  localparam int BAND_W     = LEVEL_W - FRAC_BITS;

  // Per-level step: floor(|d| * 2^FRAC_BITS / dlev), one quotient bit per cycle.
  localparam int STEP_W     = COORD_BITS + FRAC_BITS;
  // Distance to the next boundary, 0 .. 2^FRAC_BITS.
  localparam int DS_W       = FRAC_BITS + 1;
  localparam int PROD_W     = STEP_W + DS_W;
  localparam int OFF_W      = PROD_W - FRAC_BITS;
  // Signed running position; holds start plus up to MAX_POINTS + 1 steps.
  localparam int POS_W      = STEP_W + $clog2(MAX_POINTS + 2) + 2;

  localparam int BAND_SPAN  = 1 << BAND_W;
  localparam int CNT_MAX    = (BAND_SPAN > MAX_POINTS) ? BAND_SPAN : MAX_POINTS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  localparam int DIV_CYCLES = STEP_W;
  localparam int MUL_CYCLES = DS_W;
  localparam int CYC_W      = $clog2(DIV_CYCLES + MUL_CYCLES + 2);

  localparam logic [DS_W-1:0]   LEVEL_ONE = DS_W'(1 << FRAC_BITS);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_BITS - 1));

  // One edge: two screen points with their fixed-point levels.
  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [LEVEL_W-1:0]    start_level;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [LEVEL_W-1:0]    end_level;
  } ccp_seg_t;

  // One emitted point.
  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [BAND_W-1:0]     band_index;
    logic                  last_point;
  } ccp_point_t;

  // Control of a bit-serial unit.
  typedef struct packed {
    logic load;
    logic run;
  } ccp_ser_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } ccp_state_t;

endpackage

/* rtl/ccp_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: quotient = (mag << FRAC_BITS) / divisor.
module ccp_div (
  input  logic                           clk,
  input  ccp_pkg::ccp_ser_ctl_t          ctl,
  input  logic [ccp_pkg::COORD_BITS-1:0] mag,
  input  logic [ccp_pkg::LEVEL_W-1:0]    divisor,
  output logic [ccp_pkg::STEP_W-1:0]     quotient
);
  import ccp_pkg::*;

  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W-1:0] dvs;
  logic [STEP_W-1:0]  quo;
  logic [LEVEL_W:0]   shifted;
  logic [LEVEL_W:0]   diff;
  logic               fits;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    shifted = {rem, quo[STEP_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      dvs <= divisor;
      quo <= {mag, {FRAC_BITS{1'b0}}};
    end else if (ctl.run) begin
      rem <= fits ? diff[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
      quo <= {quo[STEP_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* rtl/ccp_mul.sv */
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, with rounding:
// offset = (step * ds + 2^(FRAC_BITS-1)) >> FRAC_BITS.
module ccp_mul (
  input  logic                       clk,
  input  ccp_pkg::ccp_ser_ctl_t      ctl,
  input  logic [ccp_pkg::STEP_W-1:0] step,
  input  logic [ccp_pkg::DS_W-1:0]   ds,
  output logic [ccp_pkg::OFF_W-1:0]  offset
);
  import ccp_pkg::*;

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [DS_W-1:0]   mplier;

  // The rounding constant seeds the accumulator; the multiplicand doubles each cycle.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc    <= ROUND_HALF;
      mcand  <= PROD_W'(step);
      mplier <= ds;
    end else if (ctl.run) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[DS_W-1:1]};
    end
  end

  assign offset = acc[PROD_W-1:FRAC_BITS];

endmodule

/* rtl/contour_edge_crossing_points.sv */
`timescale 1ns / 1ps

// Channel  Handshake                     Payload
// -------  ----------------------------  ---------------------------------
// edge     start / busy (start & !busy)  seg   : ccp_pkg::ccp_seg_t
// points   strobe, one cycle each        point : ccp_pkg::ccp_point_t
//
// An edge whose ends share an integer level goes straight to the emit state,
// which registers its single point. Otherwise the two bit-serial dividers run,
// then the shift-add multipliers, and the points then leave one per cycle.
// busy stays high from acceptance until the clock edge that registers the last
// point; the receiver cannot stall. Synchronous reset returns the controller
// to idle with no strobe.
module contour_edge_crossing_points (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ccp_pkg::ccp_seg_t   seg,
  output logic                strobe,
  output ccp_pkg::ccp_point_t point
);
  import ccp_pkg::*;

  ccp_state_t state;
  ccp_state_t state_next;
  logic [CYC_W-1:0] cyc;

  logic                  accept;
  logic                  lvl_up;
  logic [LEVEL_W-1:0]    dlev;
  logic [BAND_W-1:0]     b0_in;
  logic [BAND_W-1:0]     b1_in;
  logic [BAND_W-1:0]     bdiff;
  logic [CNT_W-1:0]      cnt_raw;
  logic [CNT_W-1:0]      cnt_in;
  logic [DS_W-1:0]       ds_in;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;

  logic [COORD_BITS-1:0] x0;
  logic [COORD_BITS-1:0] y0;
  logic [BAND_W-1:0]     band;
  logic                  up;
  logic                  dir_x;
  logic                  dir_y;
  logic [CNT_W-1:0]      total;
  logic [CNT_W-1:0]      k;
  logic [DS_W-1:0]       ds;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;

  ccp_ser_ctl_t         div_ctl;
  ccp_ser_ctl_t         mul_ctl;
  logic                 pos_load;
  logic                 emit;
  logic [STEP_W-1:0]    step_x;
  logic [STEP_W-1:0]    step_y;
  logic [OFF_W-1:0]     off_x;
  logic [OFF_W-1:0]     off_y;
  logic signed [POS_W-1:0] off_x_s;
  logic signed [POS_W-1:0] off_y_s;
  logic signed [POS_W-1:0] step_x_s;
  logic signed [POS_W-1:0] step_y_s;
  ccp_point_t           point_next;

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [POS_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[POS_W-1]) begin
      r = '0;
    end else if (|v[POS_W-2:COORD_BITS]) begin
      r = '1;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = state != ST_IDLE;

  // Decode the incoming edge: direction, level span, point count, first distance.
  always_comb begin
    lvl_up  = seg.end_level > seg.start_level;
    dlev    = lvl_up ? seg.end_level - seg.start_level : seg.start_level - seg.end_level;
    b0_in   = seg.start_level[LEVEL_W-1:FRAC_BITS];
    b1_in   = seg.end_level[LEVEL_W-1:FRAC_BITS];
    bdiff   = (b1_in >= b0_in) ? b1_in - b0_in : b0_in - b1_in;
    cnt_raw = CNT_W'(bdiff) + CNT_W'(1);
    cnt_in  = (cnt_raw > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_raw;
    ds_in   = lvl_up ? LEVEL_ONE - DS_W'(seg.start_level[FRAC_BITS-1:0])
                     : DS_W'(seg.start_level[FRAC_BITS-1:0]);
    mag_x   = (seg.end_x > seg.start_x) ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
    mag_y   = (seg.end_y > seg.start_y) ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;
  end

  // Per-axis step and first offset units.
  ccp_div u_div_x (.clk(clk), .ctl(div_ctl), .mag(mag_x), .divisor(dlev), .quotient(step_x));
  ccp_div u_div_y (.clk(clk), .ctl(div_ctl), .mag(mag_y), .divisor(dlev), .quotient(step_y));
  ccp_mul u_mul_x (.clk(clk), .ctl(mul_ctl), .step(step_x), .ds(ds), .offset(off_x));
  ccp_mul u_mul_y (.clk(clk), .ctl(mul_ctl), .step(step_y), .ds(ds), .offset(off_y));

  assign off_x_s  = $signed({{(POS_W-OFF_W){1'b0}}, off_x});
  assign off_y_s  = $signed({{(POS_W-OFF_W){1'b0}}, off_y});
  assign step_x_s = $signed({{(POS_W-STEP_W){1'b0}}, step_x});
  assign step_y_s = $signed({{(POS_W-STEP_W){1'b0}}, step_y});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cnt_in == CNT_W'(1)) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cyc == CYC_W'(DIV_CYCLES - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cyc == CYC_W'(MUL_CYCLES + 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (k == total - CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    div_ctl  = '0;
    mul_ctl  = '0;
    pos_load = 1'b0;
    emit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        div_ctl.load = accept;
      end
      ST_DIV: begin
        div_ctl.run = 1'b1;
      end
      ST_MUL: begin
        mul_ctl.load = cyc == '0;
        mul_ctl.run  = (cyc != '0) && (cyc <= CYC_W'(MUL_CYCLES));
        pos_load     = cyc == CYC_W'(MUL_CYCLES + 1);
      end
      ST_EMIT: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State register and phase counter, which restarts on every state change.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cyc   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cyc <= '0;
      end else begin
        cyc <= cyc + CYC_W'(1);
      end
    end
  end

  // Edge registers, first crossing and running position.
  always_ff @(posedge clk) begin
    if (accept) begin
      x0    <= seg.start_x;
      y0    <= seg.start_y;
      band  <= b0_in;
      up    <= lvl_up;
      dir_x <= seg.end_x > seg.start_x;
      dir_y <= seg.end_y > seg.start_y;
      total <= cnt_in;
      ds    <= ds_in;
      k     <= '0;
    end
    if (pos_load) begin
      px <= dir_x ? $signed({{(POS_W-COORD_BITS){1'b0}}, x0}) + off_x_s
                  : $signed({{(POS_W-COORD_BITS){1'b0}}, x0}) - off_x_s;
      py <= dir_y ? $signed({{(POS_W-COORD_BITS){1'b0}}, y0}) + off_y_s
                  : $signed({{(POS_W-COORD_BITS){1'b0}}, y0}) - off_y_s;
      sx <= dir_x ? step_x_s : -step_x_s;
      sy <= dir_y ? step_y_s : -step_y_s;
    end
    if (emit) begin
      k    <= k + CNT_W'(1);
      band <= up ? band + BAND_W'(1) : band - BAND_W'(1);
      if (k != '0) begin
        px <= px + sx;
        py <= py + sy;
      end
    end
  end

  // The start point goes out first, then one crossing per cycle.
  always_comb begin
    if (k == '0) begin
      point_next.point_x = x0;
      point_next.point_y = y0;
    end else begin
      point_next.point_x = clamp_coord(px);
      point_next.point_y = clamp_coord(py);
    end
    point_next.band_index = band;
    point_next.last_point = k == total - CNT_W'(1);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    if (emit) begin
      point <= point_next;
    end
  end

  // The final point of an edge closes the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && point.last_point |=> !strobe)
    else $error("point strobed after the last point of an edge");

  // Every point but the last leaves the block still busy with its edge.
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !point.last_point |-> busy)
    else $error("block went idle before the last point");

  // An accepted edge always occupies the block on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // Points appear only while an edge is being worked on.
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("point strobed without an edge in progress");

endmodule

/* tb/contour_edge_crossing_points_tb.sv */
`timescale 1ns / 1ps

module contour_edge_crossing_points_tb;
  import ccp_pkg::*;

  // Tracks the crossing points that each accepted edge must produce.
  class crossing_book;
    ccp_point_t pending_points[$];
    int errors;
    int edges_taken;
    int single_point_edges;
    int points_checked;

    function new();
      errors = 0;
      edges_taken = 0;
      single_point_edges = 0;
      points_checked = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    // Screen positions saturate to the coordinate range.
    function longint unsigned fit_screen(longint v);
      longint hi;
      hi = (longint'(1) << COORD_BITS) - 1;
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // Works out the start point and every level crossing of one edge.
    function void note_edge(ccp_seg_t s);
      longint unsigned one, d0, d1, b0, b1, cnt, ds, dlev, mag_x, mag_y;
      longint sx, sy, px, py, ox, oy;
      bit up;
      int total;
      ccp_point_t p;
      one = longint'(1) << FRAC_BITS;
      d0 = s.start_level;
      d1 = s.end_level;
      b0 = d0 >> FRAC_BITS;
      b1 = d1 >> FRAC_BITS;
      cnt = ((b1 >= b0) ? b1 - b0 : b0 - b1) + 1;
      if (cnt > MAX_POINTS) cnt = MAX_POINTS;
      total = int'(cnt);
      edges_taken++;

      p.point_x = s.start_x;
      p.point_y = s.start_y;
      p.band_index = BAND_W'(b0);
      p.last_point = (total == 1);
      pending_points.push_back(p);
      if (total == 1) begin
        single_point_edges++;
        return;
      end

      // Distance to the next boundary and the per-level step on each axis.
      up = d1 > d0;
      ds = d0 & (one - 1);
      if (up) ds = one - ds;
      dlev = up ? d1 - d0 : d0 - d1;
      mag_x = (s.end_x > s.start_x) ? s.end_x - s.start_x : s.start_x - s.end_x;
      mag_y = (s.end_y > s.start_y) ? s.end_y - s.start_y : s.start_y - s.end_y;
      sx = longint'(((mag_x << (2 * FRAC_BITS)) / dlev) >> FRAC_BITS);
      sy = longint'(((mag_y << (2 * FRAC_BITS)) / dlev) >> FRAC_BITS);
      ox = longint'((ds * longint'(sx) + (one >> 1)) >> FRAC_BITS);
      oy = longint'((ds * longint'(sy) + (one >> 1)) >> FRAC_BITS);
      if (s.end_x > s.start_x) begin
        px = longint'(s.start_x) + ox;
      end else begin
        px = longint'(s.start_x) - ox;
        sx = -sx;
      end
      if (s.end_y > s.start_y) begin
        py = longint'(s.start_y) + oy;
      end else begin
        py = longint'(s.start_y) - oy;
        sy = -sy;
      end

      // One point per boundary crossed, band moving one step each time.
      for (int k = 1; k < total; k++) begin
        p.point_x = COORD_BITS'(fit_screen(px));
        p.point_y = COORD_BITS'(fit_screen(py));
        p.band_index = BAND_W'(up ? b0 + k : b0 - k);
        p.last_point = (k == total - 1);
        pending_points.push_back(p);
        px += sx;
        py += sy;
      end
    endfunction

    // Compares one emitted point with the oldest one still owed.
    task check_point(ccp_point_t got);
      ccp_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point x=%0d y=%0d band=%0d last=%0b",
                                  got.point_x, got.point_y, got.band_index, got.last_point));
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      if (got.point_x !== want.point_x)
        report_mismatch($sformatf("point_x got %0d want %0d", got.point_x, want.point_x));
      if (got.point_y !== want.point_y)
        report_mismatch($sformatf("point_y got %0d want %0d", got.point_y, want.point_y));
      if (got.band_index !== want.band_index)
        report_mismatch($sformatf("band_index got %0d want %0d",
                                  got.band_index, want.band_index));
      if (got.last_point !== want.last_point)
        report_mismatch($sformatf("last_point got %0b want %0b",
                                  got.last_point, want.last_point));
    endtask

    // Anything still owed at the end of the run is a failure.
    task close_out();
      while (pending_points.size() > 0) begin
        ccp_point_t left;
        left = pending_points.pop_front();
        report_mismatch($sformatf("missing point x=%0d y=%0d band=%0d last=%0b",
                                  left.point_x, left.point_y, left.band_index,
                                  left.last_point));
      end
    endtask
  endclass

  localparam int RANDOM_EDGES = 290;
  localparam int QUIET_TAIL   = 40;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  ccp_seg_t   seg;
  logic       strobe;
  ccp_point_t point;

  crossing_book book;

  contour_edge_crossing_points u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .seg    (seg),
    .strobe (strobe),
    .point  (point)
  );

  // 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample accepted edges and emitted points at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) book.note_edge(seg);
      if (strobe) book.check_point(point);
    end
  end

  // Offers one edge and holds it until the block takes it.
  task send_edge(input ccp_seg_t s);
    @(negedge clk);
    start <= 1'b1;
    seg <= s;
    do @(posedge clk); while (busy);
  endtask

  // Leaves start low with noise on the edge fields; cycles sets the length of the burst.
  task idle_burst(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    seg <= ccp_seg_t'({$urandom, $urandom});
    repeat (cycles - 1) @(negedge clk);
  endtask

  task directed_edge(input int x0, input int y0, input int l0,
                     input int x1, input int y1, input int l1);
    ccp_seg_t s;
    s.start_x = COORD_BITS'(x0);
    s.start_y = COORD_BITS'(y0);
    s.start_level = LEVEL_W'(l0);
    s.end_x = COORD_BITS'(x1);
    s.end_y = COORD_BITS'(y1);
    s.end_level = LEVEL_W'(l1);
    if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 3));
    send_edge(s);
  endtask

  function automatic logic [COORD_BITS-1:0] random_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Mix of same-band edges, edges starting or ending on a boundary,
  // short spans and fully random level pairs.
  function automatic ccp_seg_t random_edge();
    ccp_seg_t s;
    int b0, b1;
    s.start_x = random_coord();
    s.start_y = random_coord();
    s.end_x = ($urandom_range(0, 9) == 0) ? s.start_x : random_coord();
    s.end_y = ($urandom_range(0, 9) == 0) ? s.start_y : random_coord();
    s.start_level = LEVEL_W'($urandom);
    s.end_level = LEVEL_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        s.end_level = {s.start_level[LEVEL_W-1:FRAC_BITS], FRAC_BITS'($urandom)};
      end
      2: begin
        s.start_level[FRAC_BITS-1:0] = '0;
      end
      3: begin
        s.end_level[FRAC_BITS-1:0] = '0;
      end
      4, 5: begin
        b0 = s.start_level[LEVEL_W-1:FRAC_BITS];
        b1 = ($urandom_range(0, 1) != 0) ? b0 + $urandom_range(1, 3) : b0 - $urandom_range(1, 3);
        if (b1 < 0) b1 = 0;
        if (b1 >= BAND_SPAN) b1 = BAND_SPAN - 1;
        s.end_level = {BAND_W'(b1), FRAC_BITS'($urandom)};
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    int waited;
    book = new();
    rst = 1'b1;
    start = 1'b0;
    seg = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed edges: single-band cases, full spans, boundaries, tiny spans.
    directed_edge(100, 200, 165, 300, 400, 400);
    directed_edge(0, 0, 0, 0, 0, 0);
    directed_edge(4095, 4095, 8191, 4095, 4095, 8191);
    directed_edge(0, 0, 0, 4095, 4095, 8191);
    directed_edge(4095, 4095, 8191, 0, 0, 0);
    directed_edge(1000, 3000, 1536, 3000, 1000, 200);
    directed_edge(1000, 3000, 1536, 3000, 1000, 4000);
    directed_edge(0, 4095, 511, 4095, 0, 512);
    directed_edge(4095, 0, 512, 0, 4095, 511);
    directed_edge(2048, 2048, 700, 2048, 2048, 6000);
    directed_edge(1234, 10, 8000, 1234, 4000, 100);
    directed_edge(50, 60, 100, 3000, 2000, 2048);
    directed_edge(3000, 2000, 7000, 50, 60, 1024);
    directed_edge(4000, 5, 2600, 3, 4090, 7500);
    directed_edge(0, 4095, 8191, 4095, 0, 0);
    directed_edge(4095, 0, 0, 4095, 4095, 8191);
    directed_edge(7, 4088, 4096, 4088, 7, 4607);
    directed_edge(2730, 1365, 4095, 1365, 2730, 4096);

    // Random edges, with short idle bursts except near the end.
    for (int i = 0; i < RANDOM_EDGES; i++) begin
      if (i < RANDOM_EDGES - QUIET_TAIL && $urandom_range(0, 2) == 0)
        idle_burst($urandom_range(1, 3));
      send_edge(random_edge());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding points, then watch for strays.
    waited = 0;
    while (book.pending_points.size() > 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    book.close_out();

    $display("Covered %0d edges (%0d within one band) and %0d emitted points.",
             book.edges_taken, book.single_point_edges, book.points_checked);
    if (book.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #2000000;
    $display("Timed out waiting for the block.");
    $display("Mismatches found");
    $finish;
  end

endmodule
